[design/miller_rabin_round_top_assert.svh]
// assertion macros for the miller-rabin round block
`ifndef MILLER_RABIN_ROUND_TOP_ASSERT_SVH
`define MILLER_RABIN_ROUND_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define MR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mrr_pkg.sv]
`default_nettype none
package mrr_pkg;
  localparam int Width = 64;
  localparam int CntW = $clog2(Width + 1);

  typedef logic [Width-1:0] word_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_INVALID   = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_POW,
    ST_POWSQ,
    ST_CHECK,
    ST_SQ,
    ST_DONE
  } state_t;

  // request to the shared modular multiplier
  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t n;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t r;
  } mul_rsp_t;
endpackage
`default_nettype wire

[design/mrr_mulmod.sv]
`default_nettype none
module mrr_mulmod (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mrr_pkg::mul_req_t req,
  output mrr_pkg::mul_rsp_t      rsp
);
  import mrr_pkg::*;

  word_t x, y, n, r;
  cnt_t  cnt;
  logic  busy, phase, done_q;
  logic [Width:0] sum;
  word_t addend, add_res;

  // phase 0 doubles r, phase 1 adds x when the current multiplier bit is set
  assign addend = phase ? x : r;
  assign sum = {1'b0, r} + {1'b0, addend};
  assign add_res = (sum >= {1'b0, n}) ? word_t'(sum - {1'b0, n}) : sum[Width-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        x <= req.x;
        y <= req.y;
        n <= req.n;
        r <= '0;
        cnt <= cnt_t'(Width);
        phase <= 1'b0;
      end else if (busy) begin
        if (!phase) begin
          r <= add_res;
          phase <= 1'b1;
        end else begin
          if (y[Width-1]) r <= add_res;
          y <= {y[Width-2:0], 1'b0};
          phase <= 1'b0;
          cnt <= cnt - cnt_t'(1);
          if (cnt == cnt_t'(1)) begin
            busy <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end
  assign rsp = '{done: done_q, r: r};
endmodule
`default_nettype wire

[design/mrr_ctrl.sv]
`default_nettype none
module mrr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid_in,
  output logic                   stall_in,
  input  wire mrr_pkg::word_t    candidate,
  input  wire mrr_pkg::word_t    witness,
  output logic                   valid_out,
  input  wire logic              stall_out,
  output logic [1:0]             verdict,
  output mrr_pkg::mul_req_t      req,
  input  wire mrr_pkg::mul_rsp_t rsp
);
  import mrr_pkg::*;

  state_t state, state_next;
  word_t n, nm1, q, b, x;
  cnt_t  k, j;
  logic [1:0] vd;
  logic acc;

  assign acc = valid_in && !stall_in;
  assign stall_in = (state != ST_IDLE);
  assign valid_out = (state == ST_DONE);
  assign verdict = vd;

  always_comb begin
    state_next = state;
    req = '{start: 1'b0, x: x, y: b, n: n};
    case (state)
      ST_IDLE: if (valid_in) begin
        if (candidate < word_t'(2) || (!candidate[0] && candidate != word_t'(2)))
          state_next = ST_DONE;
        else if (candidate == word_t'(2) || candidate == word_t'(3))
          state_next = ST_DONE;
        else if (witness < word_t'(2) || witness > candidate - word_t'(2))
          state_next = ST_DONE;
        else
          state_next = ST_SPLIT;
      end
      ST_SPLIT: if (q[0]) begin
        // once q is odd, start multiplying x by b; while q is even, stay here halving it
        state_next = ST_POW;
        req.start = 1'b1;
        req.y = q[0] ? b : word_t'(1);
      end
      ST_POW: if (rsp.done) begin
        state_next = ST_POWSQ;
        req = '{start: 1'b1, x: b, y: b, n: n};
      end
      ST_POWSQ: if (rsp.done) begin
        if (q == '0) state_next = ST_CHECK;
        else begin
          state_next = ST_POW;
          req = '{start: 1'b1, x: x, y: q[0] ? rsp.r : word_t'(1), n: n};
        end
      end
      ST_CHECK: begin
        if (x == word_t'(1) || x == nm1 || j >= k) state_next = ST_DONE;
        else begin
          state_next = ST_SQ;
          req = '{start: 1'b1, x: x, y: x, n: n};
        end
      end
      ST_SQ: if (rsp.done) begin
        if (rsp.r == nm1 || j + cnt_t'(1) >= k) state_next = ST_DONE;
        else req = '{start: 1'b1, x: rsp.r, y: rsp.r, n: n};
      end
      ST_DONE: if (!stall_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (acc) begin
        n <= candidate;
        nm1 <= candidate - word_t'(1);
        q <= candidate - word_t'(1);
        b <= witness;
        x <= word_t'(1);
        k <= '0;
        j <= cnt_t'(1);
        if (candidate < word_t'(2)) vd <= VERDICT_COMPOSITE;
        else if (candidate == word_t'(2) || candidate == word_t'(3)) vd <= VERDICT_PRIME;
        else if (!candidate[0]) vd <= VERDICT_COMPOSITE;
        else if (witness < word_t'(2) || witness > candidate - word_t'(2))
          vd <= VERDICT_INVALID;
      end
      ST_SPLIT: if (!q[0]) begin
        q <= q >> 1;
        k <= k + cnt_t'(1);
      end
      ST_POW: if (rsp.done) begin
        x <= rsp.r;
        q <= q >> 1;
      end
      ST_POWSQ: if (rsp.done) b <= rsp.r;
      ST_CHECK: begin
        if (x == word_t'(1) || x == nm1) vd <= VERDICT_PRIME;
        else if (j >= k) vd <= VERDICT_COMPOSITE;
      end
      ST_SQ: if (rsp.done) begin
        x <= rsp.r;
        j <= j + cnt_t'(1);
        if (rsp.r == nm1) vd <= VERDICT_PRIME;
        else if (j + cnt_t'(1) >= k) vd <= VERDICT_COMPOSITE;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[design/miller_rabin_round_top.sv]
`default_nettype none
// one miller-rabin round on a 64-bit candidate and a witness base. a beat
// is taken only while idle; special cases (n below 2, n of 2 or 3, even n,
// witness outside 2..n-2) go straight to the verdict. otherwise n-1 is split
// into q*2^k one bit a cycle, then a^q mod n is formed by square-and-multiply,
// then x is squared up to k-1 times. every modular product goes through one
// shared double-and-add unit, so a full round costs at most about 2*64
// products. the verdict beat is held until the sink takes it.
module miller_rabin_round_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                valid_in,
  output logic                     stall_in,
  input  wire mrr_pkg::word_t      candidate,
  input  wire mrr_pkg::word_t      witness,
  output logic                     valid_out,
  input  wire logic                stall_out,
  output logic [1:0]               verdict
);
  import mrr_pkg::*;
`include "miller_rabin_round_top_assert.svh"

  mul_req_t req;
  mul_rsp_t rsp;

  // sequencer: splitting, exponent walk and squaring loop
  mrr_ctrl u_ctrl (
    .clk, .rst, .valid_in, .stall_in, .candidate, .witness,
    .valid_out, .stall_out, .verdict, .req, .rsp
  );

  // shared bit-serial modular multiplier
  mrr_mulmod u_mul (.clk, .rst, .req, .rsp);

  // a finished verdict is never a reserved code
  `MR_ASSERT_IMPL(a_verdict_code, valid_out, verdict != 2'd3, "reserved verdict code")
  // no new beat is taken while a verdict waits
  `MR_ASSERT_IMPL(a_no_take_busy, valid_out, stall_in, "input taken during output")
  // multiplier start only while a round is under way
  `MR_ASSERT_IMPL(a_start_busy, req.start, stall_in && !valid_out, "stray multiply start")
  // a stalled verdict beat stays put
  `MR_ASSERT_NEXT(a_hold_out, valid_out && stall_out, valid_out && $stable(verdict), "verdict beat changed while stalled")
endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mrr_pkg::*;

  // cycle limit for the whole run, checked by the watchdog
  localparam longint CycleLimit = 12_000_000;
  localparam int HoldCycles = 40_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid_in = 1'b0;
  logic stall_in;
  logic [63:0] candidate = '0;
  logic [63:0] witness = '0;
  logic valid_out;
  logic stall_out = 1'b0;
  logic [1:0] verdict;

  verdict_t verdicts_due[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;

  // a few primes near the top of the range and below, so probable-prime verdicts are common
  logic [63:0] primes[8] = '{64'd18446744073709551557, 64'd2305843009213693951,
    64'd4294967291, 64'd1000000007, 64'd9223372036854775783, 64'd65521,
    64'd998244353, 64'd4611686018427387847};

  always #6 clk = ~clk;

  miller_rabin_round_top dut (
    .clk(clk), .rst(rst), .valid_in(valid_in), .stall_in(stall_in),
    .candidate(candidate), .witness(witness), .valid_out(valid_out),
    .stall_out(stall_out), .verdict(verdict)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sink: random stalls, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      stall_out <= 1'b1;
    end else begin
      stall_out <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // every verdict beat taken is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && valid_out && !stall_out) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict: no beat expected, actual %0d", verdict);
        errors++;
      end else begin
        if (verdict !== verdicts_due[0]) begin
          $error("verdict: expected %0d, actual %0d", verdicts_due[0], verdict);
          errors++;
        end
        void'(verdicts_due.pop_front());
      end
    end
  end

  // modular product, using a double-width product instead of the serial unit
  function automatic logic [63:0] prod_mod(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p % {64'd0, n});
  endfunction

  function automatic verdict_t round_outcome(logic [63:0] n, logic [63:0] a);
    logic [63:0] nm1, q, x, b, e;
    int k;
    if (n < 2) return VERDICT_COMPOSITE;
    if (n == 2 || n == 3) return VERDICT_PRIME;
    if (!n[0]) return VERDICT_COMPOSITE;
    if (a < 2 || a > n - 2) return VERDICT_INVALID;
    nm1 = n - 1;
    q = nm1;
    k = 0;
    while (!q[0]) begin
      q = q >> 1;
      k++;
    end
    // square-and-multiply for a^q mod n
    x = 1;
    b = a;
    e = q;
    while (e != 0) begin
      if (e[0]) x = prod_mod(x, b, n);
      b = prod_mod(b, b, n);
      e = e >> 1;
    end
    if (x == 1 || x == nm1) return VERDICT_PRIME;
    for (int j = 1; j < k; j++) begin
      x = prod_mod(x, x, n);
      if (x == nm1) return VERDICT_PRIME;
    end
    return VERDICT_COMPOSITE;
  endfunction

  // offer one beat, after a random idle gap, and hold it until taken
  task automatic send_beat(logic [63:0] n, logic [63:0] a);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      valid_in <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    valid_in <= 1'b1;
    candidate <= n;
    witness <= a;
    @(posedge clk);
    while (stall_in) @(posedge clk);
    verdicts_due.push_back(round_outcome(n, a));
  endtask

  task automatic drain;
    valid_in <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random witness in 2..n-2 inclusive for odd n of 5 or more
  function automatic logic [63:0] witness_for(logic [63:0] n);
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return 64'd2 + 64'(r % {64'd0, n - 64'd3});
  endfunction

  task automatic test_special_cases;
    send_beat(64'd0, 64'd2);
    send_beat(64'd1, '1);
    send_beat(64'd2, 64'd0);
    send_beat(64'd3, '1);
    send_beat(64'd4, 64'd2);
    send_beat(64'hFFFF_FFFF_FFFF_FFFE, 64'd5);
    send_beat(64'd5, 64'd1);              // witness below range
    send_beat(64'd5, 64'd4);              // witness n-1
    send_beat(64'd5, 64'd3);              // witness n-2, smallest valid n
    send_beat(64'd7, 64'd2);
    send_beat(64'd18446744073709551557, '1);
    send_beat(64'd18446744073709551557, 64'd18446744073709551555);
    send_beat(64'd18446744073709551557, 64'd2);
    send_beat('1, 64'd0);
    send_beat('1, 64'h5555_5555_5555_5555);
    send_beat(64'd561, 64'd2);            // carmichael number
    send_beat(64'd2047, 64'd2);           // strong pseudoprime to base 2
    send_beat(64'd2047, 64'd3);
    send_beat(64'h8000_0000_0000_0001, 64'd3); // n-1 a power of two, deepest squaring
    send_beat(64'h0000_0001_0000_0001, 64'd3);
    send_beat(64'd3215031751, 64'd2);
    send_beat(64'd65521, 64'd65519);
    drain();
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int count);
    logic [63:0] n, a;
    int pick;
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = primes[$urandom_range(0, 7)];
        a = witness_for(n);
      end else if (pick < 70) begin
        n = {$urandom, $urandom} | 64'd1;
        if (n < 5) n = 64'd5;
        a = witness_for(n);
      end else if (pick < 85) begin
        n = 64'($urandom_range(5, 65535)) | 64'd1;
        a = witness_for(n);
      end else begin
        // noise: any candidate, any witness
        n = {$urandom, $urandom};
        a = {$urandom, $urandom};
        if (pick < 90) n = 64'($urandom_range(0, 9));
      end
      send_beat(n, a);
    end
    drain();
  endtask

  // sink holds off far longer than one round, so the block stalls its input
  task automatic test_backpressure;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = HoldCycles;
    for (int i = 0; i < 4; i++) send_beat(primes[i], witness_for(primes[i]));
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_random(22, 63, 25);
    test_random(63, 22, 25);
    test_random(0, 0, 25);
    test_backpressure();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
